// File: rtl/fls_pkg.sv
// ----------------------------------------------------------------------------
// fls_pkg
// Shared types, constants and helpers of the fuzzy line-follow steering block.
// ----------------------------------------------------------------------------
package fls_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int NUM_LANES = 4;
    localparam int RPM_W     = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = SAMPLE_W + 1;
    localparam int PROD_W    = 2 * FRAC_W;

    localparam int TURN_COUNT_MAX_DEF = 255;

    localparam logic [CFG_IDX_W-1:0] REG_BLACK_FULL_BELOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_GONE_ABOVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_RISE_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_FULL_ABOVE = 2'd3;

    localparam logic [CFG_W-1:0] BLACK_FULL_BELOW_RST = 16'd4096;
    localparam logic [CFG_W-1:0] BLACK_GONE_ABOVE_RST = 16'd6144;
    localparam logic [CFG_W-1:0] WHITE_RISE_START_RST = 16'd10240;
    localparam logic [CFG_W-1:0] WHITE_FULL_ABOVE_RST = 16'd24576;

    typedef enum logic [1:0] {
        CLS_BLACK = 2'd0,
        CLS_GREY  = 2'd1,
        CLS_WHITE = 2'd2
    } cls_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] bs;
        logic [SAMPLE_W-1:0] bo;
        logic [SAMPLE_W-1:0] ws;
        logic [SAMPLE_W-1:0] wo;
        logic [SAMPLE_W-1:0] gm;
    } thr_t;

    typedef struct packed {
        logic signed [FRAC_W-1:0] n;
        logic signed [FRAC_W-1:0] d;
    } frac_t;

    typedef struct packed {
        logic ld_frac;
        logic ld_prod;
        logic ld_cls;
    } lane_ctl_t;

    // Fraction with positive denominator; zero denominator reads as 0.
    function automatic frac_t mk_frac(input logic signed [FRAC_W-1:0] n,
                                      input logic signed [FRAC_W-1:0] d);
        frac_t f;
        if (d == '0) begin
            f.n = '0;
            f.d = FRAC_W'(1);
        end else if (d < 0) begin
            f.n = -n;
            f.d = -d;
        end else begin
            f.n = n;
            f.d = d;
        end
        return f;
    endfunction

    // (25 - 10/n) * 3 for a soft-turn count n >= 2; sat marks n >= 11.
    function automatic logic signed [RPM_W-1:0] soft_rpm(input logic [3:0] n,
                                                         input logic       sat);
        logic signed [RPM_W-1:0] v;
        if (sat) begin
            v = 8'sd75;
        end else begin
            case (n)
                4'd2:    v = 8'sd60;
                4'd3:    v = 8'sd66;
                4'd4:    v = 8'sd69;
                4'd5:    v = 8'sd69;
                4'd6:    v = 8'sd72;
                4'd7:    v = 8'sd72;
                4'd8:    v = 8'sd72;
                4'd9:    v = 8'sd72;
                4'd10:   v = 8'sd72;
                default: v = 8'sd75;
            endcase
        end
        return v;
    endfunction

endpackage

// File: rtl/fls_lane.sv
// ----------------------------------------------------------------------------
// fls_lane
// One sensor lane: memberships, cross-multiplied compares, class decision.
// ----------------------------------------------------------------------------
module fls_lane (
    input  logic                          aclk,
    input  fls_pkg::lane_ctl_t            ctl,
    input  fls_pkg::thr_t                 thr,
    input  logic [fls_pkg::SAMPLE_W-1:0]  sample,
    output fls_pkg::cls_t                 cls
);
    import fls_pkg::*;

    frac_t fb, fg, fw;
    frac_t fb_reg, fg_reg, fw_reg;
    logic signed [PROD_W-1:0] p_bg_reg, p_gb_reg, p_bw_reg, p_wb_reg, p_gw_reg, p_wg_reg;
    cls_t cls_reg, cls_next;

    logic signed [FRAC_W-1:0] s_x, bs_x, bo_x, ws_x, wo_x, gm_x;

    assign s_x  = signed'({1'b0, sample});
    assign bs_x = signed'({1'b0, thr.bs});
    assign bo_x = signed'({1'b0, thr.bo});
    assign ws_x = signed'({1'b0, thr.ws});
    assign wo_x = signed'({1'b0, thr.wo});
    assign gm_x = signed'({1'b0, thr.gm});

    always_comb begin
        fb = mk_frac('0, FRAC_W'(1));
        fg = mk_frac('0, FRAC_W'(1));
        fw = mk_frac('0, FRAC_W'(1));
        if (sample < thr.bs) begin
            fb = mk_frac(FRAC_W'(1), FRAC_W'(1));
        end else if (sample > thr.wo) begin
            fw = mk_frac(FRAC_W'(1), FRAC_W'(1));
        end else if (sample < thr.gm) begin
            if (sample <= thr.bo) begin
                fb = mk_frac(s_x - bo_x, bs_x - bo_x);
            end
            fg = mk_frac(s_x - bs_x, gm_x - bs_x);
        end else begin
            if (sample < thr.wo) begin
                fg = mk_frac(s_x - wo_x, gm_x - wo_x);
            end
            if (sample >= thr.ws) begin
                fw = mk_frac(s_x - ws_x, wo_x - ws_x);
            end
        end
    end

    always_comb begin
        if (p_bg_reg > p_gb_reg) begin
            cls_next = (p_bw_reg > p_wb_reg) ? CLS_BLACK : CLS_WHITE;
        end else begin
            cls_next = (p_gw_reg > p_wg_reg) ? CLS_GREY : CLS_WHITE;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_frac) begin
            fb_reg <= fb;
            fg_reg <= fg;
            fw_reg <= fw;
        end
        if (ctl.ld_prod) begin
            p_bg_reg <= fb_reg.n * fg_reg.d;
            p_gb_reg <= fg_reg.n * fb_reg.d;
            p_bw_reg <= fb_reg.n * fw_reg.d;
            p_wb_reg <= fw_reg.n * fb_reg.d;
            p_gw_reg <= fg_reg.n * fw_reg.d;
            p_wg_reg <= fw_reg.n * fg_reg.d;
        end
        if (ctl.ld_cls) begin
            cls_reg <= cls_next;
        end
    end

    assign cls = cls_reg;

endmodule

// File: rtl/fls_merge.sv
// ----------------------------------------------------------------------------
// fls_merge
// Rule table over the four lane classes, soft-turn counters, held command.
// ----------------------------------------------------------------------------
module fls_merge #(
    parameter int TURN_COUNT_MAX = fls_pkg::TURN_COUNT_MAX_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  fls_pkg::cls_t                       wl,
    input  fls_pkg::cls_t                       fl,
    input  fls_pkg::cls_t                       fr,
    input  fls_pkg::cls_t                       wr,
    output logic signed [fls_pkg::RPM_W-1:0]    left_rpm,
    output logic signed [fls_pkg::RPM_W-1:0]    right_rpm
);
    import fls_pkg::*;

    localparam int CNT_W = $clog2(TURN_COUNT_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TURN_COUNT_MAX);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(11);

    logic [CNT_W-1:0] slc_reg, slc_next, src_reg, src_next;
    logic signed [RPM_W-1:0] held_l_reg, held_r_reg, l, r;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        return (c >= CNT_MAX) ? CNT_MAX : c + CNT_ONE;
    endfunction

    always_comb begin
        l        = held_l_reg;
        r        = held_r_reg;
        slc_next = slc_reg;
        src_next = src_reg;
        if (wl == fl && fl == fr && fr == wr) begin
            l = 8'sd0;   r = 8'sd0;
        end else if (fl == CLS_BLACK && fr == CLS_BLACK) begin
            l = 8'sd26;  r = 8'sd26;
        end else if (fl == CLS_BLACK || fr == CLS_BLACK) begin
            if (fl == CLS_GREY) begin
                if (slc_reg >= CNT_TWO) begin
                    l = 8'sd75;
                    r = soft_rpm(slc_reg[3:0], slc_reg >= CNT_SAT);
                end else begin
                    l = 8'sd25;  r = 8'sd15;
                end
                src_next = inc_sat(src_reg);
            end else if (fl == CLS_WHITE) begin
                l = 8'sd25;  r = 8'sd10;
                src_next = CNT_ONE;
            end else if (fr == CLS_GREY) begin
                if (src_reg >= CNT_TWO) begin
                    l = soft_rpm(src_reg[3:0], src_reg >= CNT_SAT);
                    r = 8'sd75;
                end else begin
                    l = 8'sd15;  r = 8'sd25;
                end
                slc_next = inc_sat(slc_reg);
            end else begin
                l = 8'sd10;  r = 8'sd25;
                slc_next = CNT_ONE;
            end
        end else if (wl == CLS_BLACK && wr == CLS_BLACK) begin
            l = 8'sd0;   r = 8'sd0;
        end else if (wl == CLS_BLACK) begin
            l = -8'sd10; r = 8'sd10;
        end else if (wr == CLS_BLACK) begin
            l = 8'sd10;  r = -8'sd10;
        end else if (fl == CLS_GREY && fr == CLS_GREY) begin
            if (wl == CLS_GREY) begin
                l = -8'sd10; r = 8'sd10;
            end else if (wr == CLS_GREY) begin
                l = 8'sd10;  r = -8'sd10;
            end
        end else if (fl == CLS_GREY) begin
            l = -8'sd10; r = 8'sd10;
        end else if (fr == CLS_GREY) begin
            l = 8'sd10;  r = -8'sd10;
        end else if (wl == CLS_GREY && wr == CLS_GREY) begin
            l = 8'sd0;   r = 8'sd0;
        end else if (wl == CLS_GREY) begin
            l = -8'sd10; r = 8'sd10;
        end else if (wr == CLS_GREY) begin
            l = 8'sd10;  r = -8'sd10;
        end else begin
            l = 8'sd0;   r = 8'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slc_reg    <= '0;
            src_reg    <= '0;
            held_l_reg <= '0;
            held_r_reg <= '0;
        end else if (fire) begin
            slc_reg    <= slc_next;
            src_reg    <= src_next;
            held_l_reg <= l;
            held_r_reg <= r;
        end
    end

    assign left_rpm  = l;
    assign right_rpm = r;

endmodule

// File: rtl/fuzzy_line_follow_steering.sv
// ----------------------------------------------------------------------------
// fuzzy_line_follow_steering
// Four-sensor fuzzy classifier and rule-based differential steering command.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | s_tdata: four 16-bit samples
//  m_       | out | m_tvalid/m_tready  | m_tdata: two rpm, four classes
//  cfg_     | in  | cfg_wr_en          | cfg_addr, cfg_wdata
//
//  Each transaction passes membership fractions, cross products, class
//  decision and the rule table into the output register; a new one is taken
//  once the previous leaves the lanes. The four lanes work side by side.
//  Reset is synchronous (aresetn low): thresholds to defaults, state cleared.
//  A stalled output holds the finished transaction in the last lane stage.
// ----------------------------------------------------------------------------
module fuzzy_line_follow_steering #(
    parameter int TURN_COUNT_MAX = fls_pkg::TURN_COUNT_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // wheel_left_sample, front_left_sample, front_right_sample, wheel_right_sample
    input  logic [63:0]                       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_rpm, right_rpm, wheel_left_class, front_left_class,
    // front_right_class, wheel_right_class
    output logic [23:0]                       m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [fls_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [fls_pkg::CFG_W-1:0]         cfg_wdata
);
    import fls_pkg::*;

    logic [CFG_W-1:0] bs_reg, bo_reg, ws_reg, wo_reg;
    logic v1_reg, v2_reg, v3_reg, m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic accept, fire;
    thr_t thr;
    lane_ctl_t ctl;
    cls_t cls [NUM_LANES];
    logic signed [RPM_W-1:0] l_rpm, r_rpm;

    assign s_tready = aresetn && !(v1_reg || v2_reg || v3_reg);
    assign accept   = s_tvalid && s_tready;
    assign fire     = v3_reg && (!m_tvalid_reg || m_tready);

    assign thr.bs = bs_reg;
    assign thr.bo = bo_reg;
    assign thr.ws = ws_reg;
    assign thr.wo = wo_reg;
    assign thr.gm = SAMPLE_W'(({1'b0, bs_reg} + {1'b0, wo_reg}) >> 1);

    assign ctl.ld_frac = accept;
    assign ctl.ld_prod = v1_reg;
    assign ctl.ld_cls  = v2_reg;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        fls_lane u_lane (
            .aclk   (aclk),
            .ctl    (ctl),
            .thr    (thr),
            .sample (s_tdata[i*SAMPLE_W +: SAMPLE_W]),
            .cls    (cls[i])
        );
    end

    fls_merge #(
        .TURN_COUNT_MAX (TURN_COUNT_MAX)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .wl        (cls[0]),
        .fl        (cls[1]),
        .fr        (cls[2]),
        .wr        (cls[3]),
        .left_rpm  (l_rpm),
        .right_rpm (r_rpm)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg       <= BLACK_FULL_BELOW_RST;
            bo_reg       <= BLACK_GONE_ABOVE_RST;
            ws_reg       <= WHITE_RISE_START_RST;
            wo_reg       <= WHITE_FULL_ABOVE_RST;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BLACK_FULL_BELOW: bs_reg <= cfg_wdata;
                    REG_BLACK_GONE_ABOVE: bo_reg <= cfg_wdata;
                    REG_WHITE_RISE_START: ws_reg <= cfg_wdata;
                    REG_WHITE_FULL_ABOVE: wo_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg || (v3_reg && !fire);
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (fire) begin
            m_tdata_reg <= {cls[3], cls[2], cls[1], cls[0], r_rpm, l_rpm};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/fuzzy_line_follow_steering_test.sv
// ----------------------------------------------------------------------------
// fuzzy_line_follow_steering_test
// Self-checking bench for the fuzzy line-follow steering block. A queue-fed
// driver sends sensor frames with random gaps, and back-pressure stalls the
// result side at random. Each accepted frame runs through a local steering
// predictor: exact fraction memberships, the rule table and the soft-turn
// counters. Its result is compared field by field in arrival order. The run
// walks through several threshold settings: default, all zero, all ones,
// misordered, zero-width ramps and random.
// ----------------------------------------------------------------------------
module fuzzy_line_follow_steering_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fls_pkg::*;

    localparam int TURN_MAX = TURN_COUNT_MAX_DEF;

    typedef struct packed {
        cls_t              wr;
        cls_t              fr;
        cls_t              fl;
        cls_t              wl;
        logic signed [7:0] right_rpm;
        logic signed [7:0] left_rpm;
    } steer_cmd_t;

    typedef struct {
        longint n;
        longint d;
    } ratio_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // wheel_left_sample, front_left_sample, front_right_sample, wheel_right_sample
    logic [63:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // left_rpm, right_rpm, wheel_left_class, front_left_class,
    // front_right_class, wheel_right_class
    logic [23:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_BLACK_FULL_BELOW;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // thresholds and steering state as the block should hold them
    logic [15:0] thr [4];
    int          soft_l_cnt;
    int          soft_r_cnt;
    int          held_l;
    int          held_r;

    logic [63:0] pending[$];
    steer_cmd_t  cmd_due[$];
    int          launched = 0;
    int          accepted = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          idling = 1'b1;
    int          bad_cnt = 0;

    fuzzy_line_follow_steering #(
        .TURN_COUNT_MAX(TURN_MAX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic ratio_t ratio(input longint n, input longint d);
        ratio_t f;
        if (d == 0) begin
            f.n = 0;
            f.d = 1;
        end else if (d < 0) begin
            f.n = -n;
            f.d = -d;
        end else begin
            f.n = n;
            f.d = d;
        end
        return f;
    endfunction

    function automatic bit ratio_gt(input ratio_t a, input ratio_t b);
        return a.n * b.d > b.n * a.d;
    endfunction

    function automatic cls_t sample_class(input logic [15:0] raw);
        longint s, bs, bo, ws, wo, gm;
        ratio_t blk, gry, wht;
        s   = raw;
        bs  = thr[REG_BLACK_FULL_BELOW];
        bo  = thr[REG_BLACK_GONE_ABOVE];
        ws  = thr[REG_WHITE_RISE_START];
        wo  = thr[REG_WHITE_FULL_ABOVE];
        gm  = (bs + wo) / 2;
        blk = ratio(0, 1);
        gry = ratio(0, 1);
        wht = ratio(0, 1);
        if (s < bs) begin
            blk = ratio(1, 1);
        end else if (s > wo) begin
            wht = ratio(1, 1);
        end else if (s < gm) begin
            if (s <= bo) blk = ratio(s - bo, bs - bo);
            gry = ratio(s - bs, gm - bs);
        end else begin
            if (s < wo) gry = ratio(s - wo, gm - wo);
            if (s >= ws) wht = ratio(s - ws, wo - ws);
        end
        if (ratio_gt(blk, gry)) return ratio_gt(blk, wht) ? CLS_BLACK : CLS_WHITE;
        return ratio_gt(gry, wht) ? CLS_GREY : CLS_WHITE;
    endfunction

    function automatic int bump(input int c);
        return (c >= TURN_MAX) ? TURN_MAX : c + 1;
    endfunction

    function automatic steer_cmd_t steer_step(input logic [63:0] frame);
        steer_cmd_t c;
        cls_t       wl, fl, fr, wr;
        int         l, r;
        wl = sample_class(frame[15:0]);
        fl = sample_class(frame[31:16]);
        fr = sample_class(frame[47:32]);
        wr = sample_class(frame[63:48]);
        l  = held_l;
        r  = held_r;
        if (wl == fl && fl == fr && fr == wr) begin
            l = 0; r = 0;
        end else if (fl == CLS_BLACK && fr == CLS_BLACK) begin
            l = 26; r = 26;
        end else if (fl == CLS_BLACK || fr == CLS_BLACK) begin
            if (fl == CLS_GREY) begin
                if (soft_l_cnt >= 2) begin
                    l = 75; r = (25 - 10 / soft_l_cnt) * 3;
                end else begin
                    l = 25; r = 15;
                end
                soft_r_cnt = bump(soft_r_cnt);
            end else if (fl == CLS_WHITE) begin
                l = 25; r = 10;
                soft_r_cnt = 1;
            end else if (fr == CLS_GREY) begin
                if (soft_r_cnt >= 2) begin
                    l = (25 - 10 / soft_r_cnt) * 3; r = 75;
                end else begin
                    l = 15; r = 25;
                end
                soft_l_cnt = bump(soft_l_cnt);
            end else begin
                l = 10; r = 25;
                soft_l_cnt = 1;
            end
        end else if (wl == CLS_BLACK && wr == CLS_BLACK) begin
            l = 0; r = 0;
        end else if (wl == CLS_BLACK) begin
            l = -10; r = 10;
        end else if (wr == CLS_BLACK) begin
            l = 10; r = -10;
        end else if (fl == CLS_GREY && fr == CLS_GREY) begin
            // neither wheel grey: previous command stays
            if (wl == CLS_GREY) begin
                l = -10; r = 10;
            end else if (wr == CLS_GREY) begin
                l = 10; r = -10;
            end
        end else if (fl == CLS_GREY) begin
            l = -10; r = 10;
        end else if (fr == CLS_GREY) begin
            l = 10; r = -10;
        end else if (wl == CLS_GREY && wr == CLS_GREY) begin
            l = 0; r = 0;
        end else if (wl == CLS_GREY) begin
            l = -10; r = 10;
        end else if (wr == CLS_GREY) begin
            l = 10; r = -10;
        end else begin
            l = 0; r = 0;
        end
        held_l      = l;
        held_r      = r;
        c.left_rpm  = 8'(l);
        c.right_rpm = 8'(r);
        c.wl        = wl;
        c.fl        = fl;
        c.fr        = fr;
        c.wr        = wr;
        return c;
    endfunction

    function automatic int idle_len();
        int p;
        if (!idling) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cls_t any_class();
        return cls_t'($urandom_range(0, 2));
    endfunction

    // samples biased toward thresholds, grey peak and the range ends
    function automatic logic [15:0] pick_sample();
        int gm;
        gm = (int'(thr[REG_BLACK_FULL_BELOW]) + int'(thr[REG_WHITE_FULL_ABOVE])) / 2;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5, 6:    return 16'(int'(thr[$urandom_range(0, 3)]) + $urandom_range(0, 600) - 300);
            7:          return 16'(gm + $urandom_range(0, 4) - 2);
            8:          return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:    return 16'(int'(thr[$urandom_range(0, 3)]) + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    // falls back to the last try when the class cannot be reached
    function automatic logic [15:0] sample_of(input cls_t want);
        logic [15:0] s;
        s = '0;
        for (int i = 0; i < 64; i++) begin
            s = pick_sample();
            if (sample_class(s) == want) return s;
        end
        return s;
    endfunction

    task automatic queue_classes(input cls_t wl, input cls_t fl, input cls_t fr, input cls_t wr);
        pending.push_back({sample_of(wr), sample_of(fr), sample_of(fl), sample_of(wl)});
    endtask

    task automatic queue_soft_run(input bit to_left, input int len);
        repeat (len) begin
            if (to_left) queue_classes(any_class(), CLS_BLACK, CLS_GREY, any_class());
            else queue_classes(any_class(), CLS_GREY, CLS_BLACK, any_class());
        end
    endtask

    task automatic queue_random(input int n);
        int k, len;
        k = 0;
        while (k < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    pending.push_back({$urandom, $urandom});
                    k++;
                end
                2, 3, 4: begin
                    queue_classes(any_class(), any_class(), any_class(), any_class());
                    k++;
                end
                5, 6: begin
                    len = $urandom_range(2, 14);
                    queue_soft_run($urandom_range(0, 1), len);
                    k += len;
                end
                7: begin
                    if ($urandom_range(0, 1))
                        queue_classes(CLS_WHITE, CLS_GREY, CLS_GREY, CLS_WHITE);
                    else
                        queue_classes(any_class(), CLS_GREY, CLS_GREY, any_class());
                    k++;
                end
                8: begin
                    if ($urandom_range(0, 1))
                        queue_classes(any_class(), CLS_WHITE, CLS_BLACK, any_class());
                    else
                        queue_classes(any_class(), CLS_BLACK, CLS_WHITE, any_class());
                    k++;
                end
                default: begin
                    pending.push_back({pick_sample(), pick_sample(), pick_sample(), pick_sample()});
                    k++;
                end
            endcase
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || launched != accepted || cmd_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        thr[idx] = val;
    endtask

    task automatic set_thresholds(input int bs, input int bo, input int ws, input int wo);
        write_reg(REG_BLACK_FULL_BELOW, 16'(bs));
        write_reg(REG_BLACK_GONE_ABOVE, 16'(bo));
        write_reg(REG_WHITE_RISE_START, 16'(ws));
        write_reg(REG_WHITE_FULL_ABOVE, 16'(wo));
        @(posedge aclk);
    endtask

    task automatic report_bad(input string what, input steer_cmd_t want, input steer_cmd_t got);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("%0t %s: want rpm %0d/%0d cls %0d %0d %0d %0d, got rpm %0d/%0d cls %0d %0d %0d %0d",
                     $realtime, what, want.left_rpm, want.right_rpm, want.wl, want.fl, want.fr,
                     want.wr, got.left_rpm, got.right_rpm, got.wl, got.fl, got.fr, got.wr);
    endtask

    // driver
    always @(negedge aclk) begin
        if (launched == accepted) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                s_tdata  <= pending.pop_front();
                s_tvalid <= 1'b1;
                launched++;
                gap_left = idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = idle_len();
        end
    end

    // monitor
    always @(posedge aclk) begin
        steer_cmd_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = steer_cmd_t'(m_tdata);
            if (cmd_due.size() == 0) begin
                report_bad("unexpected transaction", '0, got);
            end else begin
                want = cmd_due.pop_front();
                if (got.left_rpm !== want.left_rpm || got.right_rpm !== want.right_rpm ||
                    got.wl !== want.wl || got.fl !== want.fl ||
                    got.fr !== want.fr || got.wr !== want.wr)
                    report_bad("mismatch", want, got);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            cmd_due.push_back(steer_step(s_tdata));
            accepted++;
        end
    end

    initial begin
        thr[REG_BLACK_FULL_BELOW] = BLACK_FULL_BELOW_RST;
        thr[REG_BLACK_GONE_ABOVE] = BLACK_GONE_ABOVE_RST;
        thr[REG_WHITE_RISE_START] = WHITE_RISE_START_RST;
        thr[REG_WHITE_FULL_ABOVE] = WHITE_FULL_ABOVE_RST;
        soft_l_cnt = 0;
        soft_r_cnt = 0;
        held_l     = 0;
        held_r     = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        @(posedge aclk);

        // reset thresholds: range ends, break points, then every rule
        pending.push_back(64'h0);
        pending.push_back({4{16'hFFFF}});
        pending.push_back({16'd6145, 16'd6144, 16'd4096, 16'd4095});
        pending.push_back({16'd24577, 16'd24576, 16'd10240, 16'd10239});
        pending.push_back({16'd65534, 16'd14337, 16'd14336, 16'd14335});
        queue_classes(CLS_WHITE, CLS_BLACK, CLS_WHITE, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_BLACK, CLS_GREY, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_GREY, CLS_BLACK, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_GREY, CLS_BLACK, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_BLACK, CLS_GREY, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_GREY, CLS_BLACK, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_WHITE, CLS_BLACK, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_BLACK, CLS_BLACK, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_GREY, CLS_GREY, CLS_WHITE);
        queue_classes(CLS_BLACK, CLS_WHITE, CLS_WHITE, CLS_BLACK);
        queue_classes(CLS_BLACK, CLS_WHITE, CLS_WHITE, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_WHITE, CLS_WHITE, CLS_BLACK);
        queue_classes(CLS_GREY, CLS_GREY, CLS_GREY, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_GREY, CLS_GREY, CLS_GREY);
        queue_classes(CLS_WHITE, CLS_GREY, CLS_WHITE, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_WHITE, CLS_GREY, CLS_WHITE);
        queue_classes(CLS_GREY, CLS_WHITE, CLS_WHITE, CLS_GREY);
        queue_classes(CLS_GREY, CLS_WHITE, CLS_WHITE, CLS_WHITE);
        queue_classes(CLS_WHITE, CLS_WHITE, CLS_WHITE, CLS_GREY);
        queue_classes(CLS_GREY, CLS_GREY, CLS_GREY, CLS_GREY);
        queue_random(150);
        // long soft-left run drives the counter into saturation
        queue_soft_run(1'b1, 300);
        queue_soft_run(1'b0, 20);
        drain();

        set_thresholds(0, 0, 0, 0);
        queue_random(80);
        drain();

        set_thresholds(65535, 65535, 65535, 65535);
        queue_random(80);
        drain();

        idling = 1'b0;
        set_thresholds(30000, 1000, 50000, 20000);
        queue_random(120);
        drain();

        idling = 1'b1;
        set_thresholds(5000, 5000, 20000, 20000);
        queue_random(80);
        drain();

        begin
            int bs, bo, ws, wo;
            bs = $urandom_range(0, 20000);
            bo = bs + $urandom_range(0, 8000);
            ws = bo + $urandom_range(0, 10000);
            wo = ws + $urandom_range(0, 25000);
            set_thresholds(bs, bo, ws, wo);
        end
        queue_random(100);
        drain();

        set_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
        queue_random(80);
        drain();

        idling = 1'b0;
        set_thresholds(BLACK_FULL_BELOW_RST, BLACK_GONE_ABOVE_RST,
                       WHITE_RISE_START_RST, WHITE_FULL_ABOVE_RST);
        queue_random(60);
        drain();

        repeat (16) @(posedge aclk);
        if (bad_cnt == 0 && cmd_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(20ms);
        $display("status: fail");
        $finish;
    end

endmodule
